>>> rtl/ple_pkg.sv
// positional list engine package
// sizes, operation and status codes, sequencer state type; no dependencies
`default_nettype none

package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 8;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int POS_W      = $clog2(CAPACITY + 1);

    localparam logic [1:0] FUNC_GET    = 2'd0;
    localparam logic [1:0] FUNC_LOCATE = 2'd1;
    localparam logic [1:0] FUNC_INSERT = 2'd2;
    localparam logic [1:0] FUNC_REMOVE = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_LOCATE,
        S_INSERT,
        S_REMOVE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/positional_list_engine_unit.sv
// positional list engine top level: element memory plus read-modify-write sequencer
// depends on ple_pkg
`default_nettype none

// A request is taken when start is high and busy is low; its result appears on the
// result ports for one cycle with done high, and the receiver cannot hold it off.
// All elements live in one memory with one write port and one registered read port,
// so the work is paced by that memory: get reads the element at its position;
// locate reads from position 1 upward until the value is found or the list ends;
// insert moves entries up one place from the tail, then writes the new value;
// remove reads the element, then moves the entries behind it down one place.
// done is raised in the cycle after the last busy cycle. A request with a bad
// position or an insert into a full list does not raise busy and reports on the
// next cycle. No clearing pass runs after reset; the list starts empty.
module positional_list_engine_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        func,
    input  wire logic [ple_pkg::POS_W-1:0]         position,
    input  wire logic [ple_pkg::DATA_WIDTH-1:0]    value,
    output logic                                   done,
    output logic [ple_pkg::DATA_WIDTH-1:0]         read_value,
    output logic [ple_pkg::POS_W-1:0]              found_position,
    output logic [1:0]                             status,
    output logic [ple_pkg::POS_W-1:0]              length_now
);

    // element memory
    logic [ple_pkg::DATA_WIDTH-1:0] mem [ple_pkg::CAPACITY];
    logic                           mem_we;
    logic [ple_pkg::ADDR_W-1:0]     mem_waddr;
    logic [ple_pkg::DATA_WIDTH-1:0] mem_wdata;
    logic [ple_pkg::ADDR_W-1:0]     mem_raddr;
    logic [ple_pkg::DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // control state
    ple_pkg::state_t             state_reg, state_next;
    logic [ple_pkg::POS_W-1:0]   count_reg, count_next;
    logic                        pend_reg, pend_next;
    logic                        pcap_reg, pcap_next;
    logic                        done_reg, done_next;

    // working payload
    logic [ple_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [ple_pkg::DATA_WIDTH-1:0] val_reg, val_next;
    logic [ple_pkg::POS_W-1:0]      k_reg, k_next;
    logic [ple_pkg::POS_W-1:0]      paddr_reg, paddr_next;
    logic [ple_pkg::DATA_WIDTH-1:0] rem_val_reg, rem_val_next;

    // result payload
    logic [ple_pkg::DATA_WIDTH-1:0] rv_reg, rv_next;
    logic [ple_pkg::POS_W-1:0]      fp_reg, fp_next;
    logic [1:0]                     st_reg, st_next;
    logic [ple_pkg::POS_W-1:0]      len_reg, len_next;

    logic                           accept;
    logic                           pos_nonzero;
    logic                           pos_in_list;
    logic                           pos_insertable;
    logic                           list_full;
    logic [ple_pkg::POS_W-1:0]      pos_m1;
    logic [ple_pkg::POS_W-1:0]      in_pos_m1;
    logic [ple_pkg::POS_W-1:0]      k_m1;

    assign busy      = (state_reg != ple_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign pos_nonzero    = (position != '0);
    assign pos_in_list    = pos_nonzero && (position <= count_reg);
    assign pos_insertable = pos_nonzero
                            && ({1'b0, position} <= ({1'b0, count_reg} + 1'b1));
    assign list_full = (count_reg == ple_pkg::POS_W'(ple_pkg::CAPACITY));
    assign pos_m1    = pos_reg - 1'b1;
    assign in_pos_m1 = position - 1'b1;
    assign k_m1      = k_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ple_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            pcap_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            pcap_reg  <= pcap_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        k_reg       <= k_next;
        paddr_reg   <= paddr_next;
        rem_val_reg <= rem_val_next;
        rv_reg      <= rv_next;
        fp_reg      <= fp_next;
        st_reg      <= st_next;
        len_reg     <= len_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pend_next    = 1'b0;
        pcap_next    = 1'b0;
        done_next    = 1'b0;
        pos_next     = pos_reg;
        val_next     = val_reg;
        k_next       = k_reg;
        paddr_next   = paddr_reg;
        rem_val_next = rem_val_reg;
        rv_next      = rv_reg;
        fp_next      = fp_reg;
        st_next      = st_reg;
        len_next     = len_reg;
        mem_we       = 1'b0;
        mem_waddr    = in_pos_m1[ple_pkg::ADDR_W-1:0];
        mem_wdata    = val_reg;
        mem_raddr    = k_reg[ple_pkg::ADDR_W-1:0];

        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    pos_next = position;
                    val_next = value;
                    rv_next  = '0;
                    fp_next  = '0;
                    st_next  = ple_pkg::STATUS_OK;
                    len_next = count_reg;
                    unique case (func)
                        ple_pkg::FUNC_GET:
                        begin
                            if (pos_in_list)
                            begin
                                state_next = ple_pkg::S_GET;
                            end
                            else
                            begin
                                st_next   = ple_pkg::STATUS_RANGE;
                                done_next = 1'b1;
                            end
                        end
                        ple_pkg::FUNC_LOCATE:
                        begin
                            k_next     = '0;
                            state_next = ple_pkg::S_LOCATE;
                        end
                        ple_pkg::FUNC_INSERT:
                        begin
                            if (!pos_insertable)
                            begin
                                st_next   = ple_pkg::STATUS_RANGE;
                                done_next = 1'b1;
                            end
                            else if (list_full)
                            begin
                                st_next   = ple_pkg::STATUS_FULL;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = ple_pkg::S_INSERT;
                            end
                        end
                        ple_pkg::FUNC_REMOVE:
                        begin
                            if (pos_in_list)
                            begin
                                k_next     = in_pos_m1;
                                state_next = ple_pkg::S_REMOVE;
                            end
                            else
                            begin
                                st_next   = ple_pkg::STATUS_RANGE;
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ple_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            ple_pkg::S_GET:
            begin
                mem_raddr = pos_m1[ple_pkg::ADDR_W-1:0];
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    rv_next    = rd_data_reg;
                    done_next  = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
            end

            ple_pkg::S_LOCATE:
            begin
                if (pend_reg && (rd_data_reg == val_reg))
                begin
                    fp_next    = paddr_reg + 1'b1;
                    done_next  = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
                else if (k_reg < count_reg)
                begin
                    pend_next  = 1'b1;
                    paddr_next = k_reg;
                    k_next     = k_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
            end

            ple_pkg::S_INSERT:
            begin
                // shift entries up from the tail, one read and one write per cycle
                mem_raddr = k_m1[ple_pkg::ADDR_W-1:0];
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = paddr_reg[ple_pkg::ADDR_W-1:0];
                    mem_wdata = rd_data_reg;
                end
                if (k_reg >= pos_reg)
                begin
                    pend_next  = 1'b1;
                    paddr_next = k_reg;
                    k_next     = k_m1;
                end
                else if (!pend_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_m1[ple_pkg::ADDR_W-1:0];
                    mem_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                    len_next   = count_reg + 1'b1;
                    done_next  = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
            end

            ple_pkg::S_REMOVE:
            begin
                // first read fetches the removed element, later reads shift down
                if (pend_reg)
                begin
                    if (pcap_reg)
                    begin
                        rem_val_next = rd_data_reg;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = paddr_reg[ple_pkg::ADDR_W-1:0];
                        mem_wdata = rd_data_reg;
                    end
                end
                if (k_reg < count_reg)
                begin
                    pend_next  = 1'b1;
                    pcap_next  = (k_reg == pos_m1);
                    paddr_next = k_m1;
                    k_next     = k_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    rv_next    = rem_val_reg;
                    count_next = count_reg - 1'b1;
                    len_next   = count_reg - 1'b1;
                    done_next  = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    assign done           = done_reg;
    assign read_value     = rv_reg;
    assign found_position = fp_reg;
    assign status         = st_reg;
    assign length_now     = len_reg;

endmodule

`default_nettype wire
